>>> rtl/lrd_pkg.sv
// Package: shared types, codes, reset values and the low system area map of the LoROM decoder.
package lrd_pkg;

    // Field widths of one bus access and of one decode result.
    localparam int AddrWidth   = 24;
    localparam int DataWidth   = 16;
    localparam int CyclesWidth = 10;
    localparam int TimingWidth = 8;
    localparam int CfgIdxWidth = 2;

    // Component codes.
    typedef enum logic [3:0] {
        COMP_RAM          = 4'd0,
        COMP_INDIRECT_RAM = 4'd1,
        COMP_PPU          = 4'd2,
        COMP_APU          = 4'd3,
        COMP_DMA          = 4'd4,
        COMP_MATHS        = 4'd5,
        COMP_IRQ          = 4'd6,
        COMP_ROM          = 4'd7,
        COMP_SRAM         = 4'd8,
        COMP_BUS_INTERNAL = 4'd9,
        COMP_JOYPADS      = 4'd10
    } comp_t;

    // Fault codes.
    typedef enum logic [1:0] {
        FAULT_NONE     = 2'd0,
        FAULT_UNMAPPED = 2'd1,
        FAULT_DENIED   = 2'd2
    } fault_t;

    // Access kinds a range accepts: bit 0 read, bit 1 write.
    typedef enum logic [1:0] {
        ACC_NONE = 2'd0,
        ACC_R    = 2'd1,
        ACC_W    = 2'd2,
        ACC_RW   = 2'd3
    } acc_t;

    // Per-byte timing selector.
    typedef enum logic [1:0] {
        TIM_RAM  = 2'd0,
        TIM_FAST = 2'd1,
        TIM_SLOW = 2'd2,
        TIM_ROM  = 2'd3
    } tim_t;

    // Operation codes.
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Configuration register indexes.
    localparam logic [CfgIdxWidth-1:0] CFG_RAM_CYCLES  = 2'd0;
    localparam logic [CfgIdxWidth-1:0] CFG_FAST_CYCLES = 2'd1;
    localparam logic [CfgIdxWidth-1:0] CFG_SLOW_CYCLES = 2'd2;
    localparam logic [CfgIdxWidth-1:0] CFG_ROM_CYCLES  = 2'd3;

    // Reset values of the timing registers.
    localparam logic [TimingWidth-1:0] RAM_CYCLES_RESET  = 8'd8;
    localparam logic [TimingWidth-1:0] FAST_CYCLES_RESET = 8'd6;
    localparam logic [TimingWidth-1:0] SLOW_CYCLES_RESET = 8'd12;
    localparam logic [TimingWidth-1:0] ROM_CYCLES_RESET  = 8'd8;

    // One bus access.
    typedef struct packed {
        logic                   operation;
        logic [AddrWidth-1:0]   bus_address;
        logic [1:0]             access_bytes;
        logic [DataWidth-1:0]   write_data;
    } in_item_t;

    // One decode result.
    typedef struct packed {
        logic [3:0]             component;
        logic [AddrWidth-1:0]   local_address;
        logic [CyclesWidth-1:0] access_cycles;
        logic [1:0]             fault;
        logic [DataWidth-1:0]   data_out;
    } out_item_t;

    // Timing register contents handed to the decoder.
    typedef struct packed {
        logic [TimingWidth-1:0] ram_cycles;
        logic [TimingWidth-1:0] fast_cycles;
        logic [TimingWidth-1:0] slow_cycles;
        logic [TimingWidth-1:0] rom_cycles;
    } cfg_t;

    // One entry of the low system area map.
    typedef struct packed {
        logic [15:0] lo;
        logic [15:0] hi;
        comp_t       comp;
        acc_t        acc;
        tim_t        tim;
    } sys_range_t;

    // Result of a map lookup.
    typedef struct packed {
        logic  found;
        comp_t comp;
        acc_t  acc;
        tim_t  tim;
    } sys_hit_t;

    localparam int SysMapLen = 18;

    // Low system area map: banks 0x00-0x3F, offsets 0x0000-0x7FFF. Earlier entries win.
    localparam sys_range_t SYS_MAP [SysMapLen] = '{
        '{16'h0000, 16'h1FFF, COMP_RAM,          ACC_RW, TIM_RAM },
        '{16'h2180, 16'h2180, COMP_INDIRECT_RAM, ACC_RW, TIM_RAM },
        '{16'h2181, 16'h2183, COMP_INDIRECT_RAM, ACC_W,  TIM_RAM },
        '{16'h2100, 16'h2133, COMP_PPU,          ACC_W,  TIM_FAST},
        '{16'h2134, 16'h213F, COMP_PPU,          ACC_R,  TIM_FAST},
        '{16'h2140, 16'h217F, COMP_APU,          ACC_RW, TIM_FAST},
        '{16'h4300, 16'h437F, COMP_DMA,          ACC_RW, TIM_FAST},
        '{16'h420B, 16'h420C, COMP_DMA,          ACC_RW, TIM_FAST},
        '{16'h4202, 16'h4206, COMP_MATHS,        ACC_W,  TIM_FAST},
        '{16'h4214, 16'h4217, COMP_MATHS,        ACC_R,  TIM_FAST},
        '{16'h4200, 16'h4200, COMP_IRQ,          ACC_RW, TIM_FAST},
        '{16'h4207, 16'h420A, COMP_IRQ,          ACC_RW, TIM_FAST},
        '{16'h4210, 16'h4212, COMP_IRQ,          ACC_RW, TIM_FAST},
        '{16'h420D, 16'h420D, COMP_BUS_INTERNAL, ACC_RW, TIM_FAST},
        '{16'h4016, 16'h4017, COMP_JOYPADS,      ACC_RW, TIM_SLOW},
        '{16'h4201, 16'h4201, COMP_JOYPADS,      ACC_RW, TIM_FAST},
        '{16'h4213, 16'h4213, COMP_JOYPADS,      ACC_RW, TIM_FAST},
        '{16'h4218, 16'h421F, COMP_JOYPADS,      ACC_RW, TIM_FAST}
    };

    // Parallel range compare over the map; the lowest matching entry is taken.
    function automatic sys_hit_t sys_lookup(input logic [15:0] off);
        sys_hit_t hit;
        hit.found = 1'b0;
        hit.comp  = COMP_RAM;
        hit.acc   = ACC_NONE;
        hit.tim   = TIM_RAM;
        for (int i = SysMapLen - 1; i >= 0; i--)
        begin
            if (off >= SYS_MAP[i].lo && off <= SYS_MAP[i].hi)
            begin
                hit.found = 1'b1;
                hit.comp  = SYS_MAP[i].comp;
                hit.acc   = SYS_MAP[i].acc;
                hit.tim   = SYS_MAP[i].tim;
            end
        end
        return hit;
    endfunction

endpackage

>>> rtl/lrd_cfg_regs.sv
// Timing configuration registers of the LoROM decoder.
module lrd_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [lrd_pkg::CfgIdxWidth-1:0]    cfg_index,
    input  logic [lrd_pkg::TimingWidth-1:0]    cfg_data,
    output lrd_pkg::cfg_t                      cfg
);

    lrd_pkg::cfg_t cfg_reg;
    lrd_pkg::cfg_t cfg_next;

    // Select the register addressed by the write.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                lrd_pkg::CFG_RAM_CYCLES:  cfg_next.ram_cycles  = cfg_data;
                lrd_pkg::CFG_FAST_CYCLES: cfg_next.fast_cycles = cfg_data;
                lrd_pkg::CFG_SLOW_CYCLES: cfg_next.slow_cycles = cfg_data;
                lrd_pkg::CFG_ROM_CYCLES:  cfg_next.rom_cycles  = cfg_data;
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ram_cycles  <= lrd_pkg::RAM_CYCLES_RESET;
            cfg_reg.fast_cycles <= lrd_pkg::FAST_CYCLES_RESET;
            cfg_reg.slow_cycles <= lrd_pkg::SLOW_CYCLES_RESET;
            cfg_reg.rom_cycles  <= lrd_pkg::ROM_CYCLES_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/lrd_decode.sv
// Combinational decode of one registered bus access into a component result.
module lrd_decode (
    input  lrd_pkg::in_item_t  item,
    input  lrd_pkg::cfg_t      cfg,
    output lrd_pkg::out_item_t result
);

    logic [7:0]                       bank;
    logic [15:0]                      off;
    logic [7:0]                       tb;
    lrd_pkg::sys_hit_t                sys_hit;
    logic                             found;
    lrd_pkg::comp_t                   comp;
    lrd_pkg::acc_t                    acc;
    lrd_pkg::tim_t                    tim;
    logic                             allowed;
    logic [lrd_pkg::AddrWidth-1:0]    local_addr;
    logic [lrd_pkg::TimingWidth-1:0]  per_byte;
    logic [lrd_pkg::CyclesWidth-1:0]  cycles;

    assign bank = item.bus_address[23:16];
    assign off  = item.bus_address[15:0];

    // Banks 0x80-0xFD mirror banks 0x00-0x7D.
    assign tb = (bank >= 8'h80 && bank <= 8'hFD) ? {1'b0, bank[6:0]} : bank;

    assign sys_hit = lrd_pkg::sys_lookup(off);

    // Region select: low system area, work RAM banks, ROM, otherwise SRAM.
    always_comb
    begin
        found = 1'b1;
        comp  = lrd_pkg::COMP_SRAM;
        acc   = lrd_pkg::ACC_RW;
        tim   = lrd_pkg::TIM_RAM;
        if (tb <= 8'h3F && off <= 16'h7FFF)
        begin
            found = sys_hit.found;
            comp  = sys_hit.comp;
            acc   = sys_hit.acc;
            tim   = sys_hit.tim;
        end
        else if (tb == 8'h7E || tb == 8'h7F)
        begin
            comp = lrd_pkg::COMP_RAM;
        end
        else if (off >= 16'h8000 || tb <= 8'h6F)
        begin
            comp = lrd_pkg::COMP_ROM;
            acc  = lrd_pkg::ACC_R;
            tim  = lrd_pkg::TIM_ROM;
        end
    end

    assign allowed = (item.operation == lrd_pkg::OP_WRITE) ? acc[1] : acc[0];

    // Component-local address of the first byte.
    always_comb
    begin
        case (comp)
            lrd_pkg::COMP_RAM:
            begin
                // Low mirror gives the offset; banks 0x7E-0x7F give a 17-bit address.
                if (tb >= 8'h7E)
                    local_addr = {7'd0, tb[0], off};
                else
                    local_addr = {8'd0, off};
            end
            // Banks 0xFE-0xFF act as banks 0x7E-0x7F, so the low seven bank bits suffice.
            lrd_pkg::COMP_ROM:          local_addr = {2'd0, tb[6:0], off[14:0]};
            // Banks 0x70-0x7D map to 0x0-0xD and 0xFE-0xFF to 0xE-0xF.
            lrd_pkg::COMP_SRAM:         local_addr = {5'd0, tb[3:0], off[14:0]};
            lrd_pkg::COMP_MATHS:        local_addr = {tb, off};
            lrd_pkg::COMP_BUS_INTERNAL: local_addr = item.bus_address;
            default:                    local_addr = {8'd0, off};
        endcase
    end

    // Per-byte timing times the access width.
    always_comb
    begin
        case (tim)
            lrd_pkg::TIM_RAM:  per_byte = cfg.ram_cycles;
            lrd_pkg::TIM_FAST: per_byte = cfg.fast_cycles;
            lrd_pkg::TIM_SLOW: per_byte = cfg.slow_cycles;
            default:           per_byte = cfg.rom_cycles;
        endcase
    end

    assign cycles = ({2'd0, per_byte} & {lrd_pkg::CyclesWidth{item.access_bytes[0]}})
                  + ({1'b0, per_byte, 1'b0} & {lrd_pkg::CyclesWidth{item.access_bytes[1]}});

    // Assemble the result; a fault clears every other field.
    always_comb
    begin
        result.component     = '0;
        result.local_address = '0;
        result.access_cycles = '0;
        result.data_out      = '0;
        if (!found)
        begin
            result.fault = lrd_pkg::FAULT_UNMAPPED;
        end
        else if (!allowed)
        begin
            result.fault = lrd_pkg::FAULT_DENIED;
        end
        else
        begin
            result.fault         = lrd_pkg::FAULT_NONE;
            result.component     = comp;
            result.local_address = local_addr;
            result.access_cycles = cycles;
            if (item.operation == lrd_pkg::OP_WRITE)
            begin
                if (item.access_bytes == 2'd1 || comp == lrd_pkg::COMP_BUS_INTERNAL)
                    result.data_out = {8'd0, item.write_data[7:0]};
                else
                    result.data_out = item.write_data;
            end
        end
    end

endmodule

>>> rtl/lorom_bus_address_decoder.sv
// Top level of the LoROM bus address decoder: input register, decode, result register.
//
//   Channel  Signals                          Direction  Transfer when
//   input    in_valid, in_stall, in_data      in         in_valid && !in_stall
//   output   out_valid, out_stall, out_data   out        out_valid && !out_stall
//   config   cfg_wr_en, cfg_index, cfg_data   in         cfg_wr_en
//
// Each access passes through the input register, then through the decode logic into
// the result register. A new access is accepted every cycle unless in_stall is
// high. Reset clears both valid flags and loads the timing registers with their
// defaults. A stalled output holds the result register; the input register keeps
// filling, and in_stall rises only when both are occupied.
module lorom_bus_address_decoder (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  lrd_pkg::in_item_t                  in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output lrd_pkg::out_item_t                 out_data,
    input  logic                               cfg_wr_en,
    input  logic [lrd_pkg::CfgIdxWidth-1:0]    cfg_index,
    input  logic [lrd_pkg::TimingWidth-1:0]    cfg_data
);

    lrd_pkg::cfg_t      cfg;
    lrd_pkg::out_item_t decoded;

    logic               s1_valid_reg;
    logic               s1_valid_next;
    lrd_pkg::in_item_t  s1_item_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    lrd_pkg::out_item_t out_item_reg;

    logic               out_load;
    logic               s1_load;

    lrd_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lrd_decode u_decode (
        .item   (s1_item_reg),
        .cfg    (cfg),
        .result (decoded)
    );

    // The result register can take a new result when empty or when its transfer completes.
    assign out_load = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !out_load;
    assign s1_load  = in_valid && !in_stall;

    assign s1_valid_next  = s1_load || (s1_valid_reg && !out_load);
    assign out_valid_next = out_load || (out_valid_reg && out_stall);

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s1_load)
            s1_item_reg <= in_data;
        if (out_load)
            out_item_reg <= decoded;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

endmodule
